@@ design/iprh_pkg.sv @@
`timescale 1ns / 1ps
package iprh_pkg;

    localparam int MAX_ROUTES     = 16;
    localparam int MAX_INTERFACES = 16;
    localparam int CNT_W          = $clog2(MAX_ROUTES + 1);

    localparam logic [3:0]  IP_VERSION = 4'd4;
    localparam logic [3:0]  IP_IHL     = 4'd5;
    localparam logic [15:0] HDR_BYTES  = 16'd20;
    localparam logic [15:0] DF_FLAG    = 16'h4000;
    localparam logic [7:0]  TTL_VALUE  = 8'd64;
    localparam logic [2:0]  LAST_WORD  = 3'd4;

    typedef enum logic {
        ACT_ROUTE_WRITE = 1'b0,
        ACT_SEND        = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NO_ROUTE      = 2'd1,
        ST_LEN_TOO_LARGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_ROUTE_COUNT  = 2'd0,
        CFG_GW_PRESENT   = 2'd1,
        CFG_GW_INTERFACE = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SUM,
        S_EMIT
    } state_t;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [31:0]      dst;
        logic [CNT_W-1:0] left;
        logic             hit;
        logic             prefix_nz;
        logic [3:0]       iface;
    } rt_tok_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  slot;
        logic [31:0] mask;
        logic [31:0] match;
        logic [5:0]  prefix;
        logic [3:0]  iface;
    } rt_wr_t;

endpackage

@@ design/iprh_route_cell.sv @@
`timescale 1ns / 1ps
module iprh_route_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            sel,
    input  iprh_pkg::rt_wr_t  wr,
    input  iprh_pkg::rt_tok_t tok_in,
    output iprh_pkg::rt_tok_t tok_out
);
    import iprh_pkg::*;

    logic [31:0] mask_reg;
    logic [31:0] match_reg;
    logic [5:0]  prefix_reg;
    logic [3:0]  iface_reg;
    rt_tok_t     tok_reg;
    rt_tok_t     tok_next;

    always_ff @(posedge aclk) begin
        if (wr.en && sel) begin
            mask_reg   <= wr.mask;
            match_reg  <= wr.match;
            prefix_reg <= wr.prefix;
            iface_reg  <= wr.iface;
        end
    end

    always_comb begin
        tok_next = tok_in;
        if (tok_in.left != '0) begin
            tok_next.left = tok_in.left - CNT_W'(1);
            // first fitting entry wins, later cells only pass the token on
            if (!tok_in.hit && ((tok_in.dst & mask_reg) == match_reg)) begin
                tok_next.hit       = 1'b1;
                tok_next.prefix_nz = (prefix_reg != 6'd0);
                tok_next.iface     = iface_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_in.valid;
        end
        tok_reg.dst       <= tok_next.dst;
        tok_reg.left      <= tok_next.left;
        tok_reg.hit       <= tok_next.hit;
        tok_reg.prefix_nz <= tok_next.prefix_nz;
        tok_reg.iface     <= tok_next.iface;
    end

    assign tok_out = tok_reg;

endmodule

@@ design/iprh_route_chain.sv @@
`timescale 1ns / 1ps
module iprh_route_chain (
    input  logic            aclk,
    input  logic            aresetn,
    input  iprh_pkg::rt_wr_t  wr,
    input  iprh_pkg::rt_tok_t tok_in,
    output iprh_pkg::rt_tok_t tok_out
);
    import iprh_pkg::*;

    rt_tok_t link [MAX_ROUTES+1];

    assign link[0] = tok_in;

    for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
        logic sel;
        assign sel = ({28'd0, wr.slot} == 32'(i));

        iprh_route_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .sel     (sel),
            .wr      (wr),
            .tok_in  (link[i]),
            .tok_out (link[i+1])
        );
    end

    assign tok_out = link[MAX_ROUTES];

endmodule

@@ design/ipv4_route_and_header_gen.sv @@
`timescale 1ns / 1ps
// IPv4 route lookup and header generator. A route_write beat (tuser 0) loads one
// slot of the route table and gives no result. A send beat (tuser 1) either uses
// the interface it carries or sends a lookup token down a row of MAX_ROUTES (16)
// route cells, one cell per cycle, through every cell whatever route_count
// holds. After a decide state and a checksum state the five header words leave
// on the master side, one per cycle when m_tready is held high; a failed send
// gives a single status beat instead. The block takes one send at a time.
// Configuration writes are accepted every cycle and must only be made while the
// block is idle.
module ipv4_route_and_header_gen (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [4:0]   cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // route_slot, prefix_len, interface_req, given_external, dst_or_match,
    // src_or_mask, protocol, ip_id, tos, payload_len
    input  logic [127:0] s_tdata,
    // action
    input  logic         s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // header_word, word_index, out_interface, via_gateway
    output logic [39:0]  m_tdata,
    output logic         m_tlast,
    // status
    output logic [1:0]   m_tuser
);
    import iprh_pkg::*;

    // unpacked input fields
    logic [3:0]  in_slot;
    logic [5:0]  in_prefix;
    logic [4:0]  in_ireq;
    logic        in_gext;
    logic [31:0] in_dst;
    logic [31:0] in_src;
    logic [7:0]  in_proto;
    logic [15:0] in_id;
    logic [7:0]  in_tos;
    logic [15:0] in_plen;

    assign in_slot   = s_tdata[3:0];
    assign in_prefix = s_tdata[9:4];
    assign in_ireq   = s_tdata[14:10];
    assign in_gext   = s_tdata[15];
    assign in_dst    = s_tdata[47:16];
    assign in_src    = s_tdata[79:48];
    assign in_proto  = s_tdata[87:80];
    assign in_id     = s_tdata[103:88];
    assign in_tos    = s_tdata[111:104];
    assign in_plen   = s_tdata[127:112];

    // configuration registers
    logic [4:0] route_count_reg;
    logic       gw_present_reg;
    logic [3:0] gw_iface_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_count_reg <= 5'd0;
            gw_present_reg  <= 1'b0;
            gw_iface_reg    <= 4'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROUTE_COUNT:  route_count_reg <= cfg_data;
                CFG_GW_PRESENT:   gw_present_reg  <= cfg_data[0];
                CFG_GW_INTERFACE: gw_iface_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // state and held item
    state_t      state_reg;
    state_t      state_next;
    logic [31:0] dst_reg;
    logic [31:0] src_reg;
    logic [7:0]  proto_reg;
    logic [15:0] id_reg;
    logic [7:0]  tos_reg;
    logic [16:0] total_reg;
    logic        found_reg;
    logic [3:0]  iface_reg;
    logic        ext_reg;
    logic [19:0] sum_reg;
    logic [2:0]  widx_reg;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic [1:0]  m_tuser_reg;

    logic        in_beat;
    logic        is_send;
    logic        launch;
    logic        out_free;
    logic        out_load;
    logic        route_fail;
    logic        len_fail;
    rt_wr_t      route_wr;
    rt_tok_t     tok_launch;
    rt_tok_t     tok_done;
    logic [4:0]  scan_count;
    logic [19:0] sum_next;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] csum;
    logic [31:0] word_sel;
    logic [39:0] out_data;
    logic        out_last;
    status_t     out_status;

    assign in_beat  = s_tvalid && s_tready;
    assign is_send  = (action_t'(s_tuser) == ACT_SEND);
    assign out_free = !m_tvalid_reg || m_tready;

    assign scan_count = (route_count_reg > 5'(MAX_ROUTES)) ? 5'(MAX_ROUTES)
                                                           : route_count_reg;

    assign route_fail = !found_reg || ({1'b0, iface_reg} >= 5'(MAX_INTERFACES));
    assign len_fail   = total_reg[16];

    always_comb begin
        route_wr.en     = in_beat && !is_send;
        route_wr.slot   = in_slot;
        route_wr.mask   = in_src;
        route_wr.match  = in_dst;
        route_wr.prefix = in_prefix;
        route_wr.iface  = in_ireq[3:0];
    end

    always_comb begin
        tok_launch.valid     = launch;
        tok_launch.dst       = in_dst;
        tok_launch.left      = launch ? CNT_W'(scan_count) : '0;
        tok_launch.hit       = 1'b0;
        tok_launch.prefix_nz = 1'b0;
        tok_launch.iface     = 4'd0;
    end

    iprh_route_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (route_wr),
        .tok_in  (tok_launch),
        .tok_out (tok_done)
    );

    // ones' complement sum of the ten header half-words, checksum field as zero
    assign sum_next = 20'({IP_VERSION, IP_IHL, tos_reg}) + 20'(total_reg[15:0])
                    + 20'(id_reg) + 20'(DF_FLAG) + 20'({TTL_VALUE, proto_reg})
                    + 20'(src_reg[31:16]) + 20'(src_reg[15:0])
                    + 20'(dst_reg[31:16]) + 20'(dst_reg[15:0]);

    assign fold1 = 17'(sum_reg[15:0]) + 17'(sum_reg[19:16]);
    assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
    assign csum  = ~fold2[15:0];

    always_comb begin
        unique case (widx_reg)
            3'd0:    word_sel = {IP_VERSION, IP_IHL, tos_reg, total_reg[15:0]};
            3'd1:    word_sel = {id_reg, DF_FLAG};
            3'd2:    word_sel = {TTL_VALUE, proto_reg, csum};
            3'd3:    word_sel = src_reg;
            3'd4:    word_sel = dst_reg;
            default: word_sel = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && is_send) begin
                    state_next = in_ireq[4] ? S_SCAN : S_DECIDE;
                end
            end
            S_SCAN: begin
                if (tok_done.valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (route_fail || len_fail) begin
                    if (out_free) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_SUM;
                end
            end
            S_SUM: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free && widx_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the control
    always_comb begin
        s_tready   = 1'b0;
        launch     = 1'b0;
        out_load   = 1'b0;
        out_data   = 40'd0;
        out_last   = 1'b0;
        out_status = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                launch   = s_tvalid && is_send && in_ireq[4];
            end
            S_DECIDE: begin
                if (route_fail) begin
                    out_load   = out_free;
                    out_last   = 1'b1;
                    out_status = ST_NO_ROUTE;
                end else if (len_fail) begin
                    out_load   = out_free;
                    out_last   = 1'b1;
                    out_status = ST_LEN_TOO_LARGE;
                    out_data   = {ext_reg, iface_reg, 3'd0, 32'd0};
                end
            end
            S_EMIT: begin
                out_load   = out_free;
                out_last   = (widx_reg == LAST_WORD);
                out_data   = {ext_reg, iface_reg, widx_reg, word_sel};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && in_beat && is_send) begin
            dst_reg   <= in_dst;
            src_reg   <= in_src;
            proto_reg <= in_proto;
            id_reg    <= in_id;
            tos_reg   <= in_tos;
            total_reg <= 17'(in_plen) + 17'(HDR_BYTES);
            found_reg <= 1'b1;
            iface_reg <= in_ireq[3:0];
            ext_reg   <= in_gext;
        end else if (state_reg == S_SCAN && tok_done.valid) begin
            // prefix zero sends through the gateway, if there is one
            found_reg <= tok_done.hit && (tok_done.prefix_nz || gw_present_reg);
            iface_reg <= tok_done.prefix_nz ? tok_done.iface : gw_iface_reg;
            ext_reg   <= !tok_done.prefix_nz;
        end
        if (state_reg == S_SUM) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg <= 3'd0;
        end else if (state_reg == S_SUM) begin
            widx_reg <= 3'd0;
        end else if (state_reg == S_EMIT && out_free) begin
            widx_reg <= widx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= out_data;
            m_tlast_reg <= out_last;
            m_tuser_reg <= out_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // a token leaves the row only during a lookup
    assert property (@(posedge aclk) disable iff (!aresetn)
        tok_done.valid |-> state_reg == S_SCAN)
        else $error("lookup token out of the route row outside a scan");

    // a status beat always closes the send
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tlast)
        else $error("status beat without last");

    // last ok beat is the destination word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tuser == ST_OK |-> m_tdata[34:32] == LAST_WORD)
        else $error("header ended on the wrong word");

    // an accepted send keeps the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("send accepted but block still idle");

endmodule
